>>> design/irt_pkg.sv
`default_nettype none

package irt_pkg;

  // Table geometry
  localparam int ENTRIES = 64;
  localparam int TIME_W  = 32;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_BOOKED   = 2'd0,
    ST_CONFLICT = 2'd1,
    ST_FULL     = 2'd2,
    ST_INVALID  = 2'd3
  } status_t;

  // Controller -> datapath
  typedef struct packed {
    logic load_req;  // capture request, rewind scan
    logic rd_en;     // read the entry at the scan index, advance index
    logic cmp_en;    // compare last read entry against request
    logic commit;    // publish verdict, store interval if booked
  } irt_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic invalid;   // end not past start
    logic full;      // every slot taken
    logic hit;       // overlap found so far
    logic idx_done;  // every stored entry has been read
    logic out_free;  // result register can take a new verdict
  } irt_sts_t;

endpackage

`default_nettype wire

>>> design/interval_reservation_table_top.sv
// A request is decided after a scan of the n stored intervals, stopped early on a
//   conflict; an invalid request or a full table decides without reading any entry.
// The single read port of the interval memory sets the throughput, one stored entry
//   scanned per cycle; the next request is taken only once the verdict is committed.
// Reset (rst, synchronous, active high) empties the table at once through the fill count;
//   no clearing pass is needed, and the next cycle can take a request.
`default_nettype none

module interval_reservation_table_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // Request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] start_time,
  input  wire logic [31:0] end_time,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status
);

  // The controller sequences one request at a time: capture, scan the stored
  // intervals through the memory read port (one read issued per cycle, compare
  // in the cycle after), then commit the verdict into the result register.
  // The result register parts the two channels, so a new request transfer is
  // taken while an earlier verdict still waits on out_ready.
  irt_pkg::irt_cmd_t cmd;
  irt_pkg::irt_sts_t sts;

  irt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Datapath: request registers, interval memory, fill count, overlap compare,
  // and the result register.
  irt_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .start_time (start_time),
    .end_time   (end_time),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status)
  );

  // Only one request in flight: after a transfer, hold off the next one.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in flight");

  // Never overwrite a verdict that has not been taken.
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> sts.out_free)
    else $error("verdict committed over a pending result");

  // A clean, non-conflicting request with room must come out booked.
  a_booked: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && !sts.invalid && !sts.full && !sts.hit)
      |=> (out_valid && status == irt_pkg::ST_BOOKED))
    else $error("free interval not reported as booked");

endmodule

`default_nettype wire

>>> design/irt_ctrl.sv
`default_nettype none

module irt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output irt_pkg::irt_cmd_t      cmd,
  input  wire irt_pkg::irt_sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   rd_pending;
  logic   stop;

  assign stop = sts.invalid | sts.full | sts.hit;

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.cmp_en = rd_pending;
        cmd.rd_en  = !stop && !sts.idx_done;
        if (stop || sts.idx_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rd_pending <= 1'b0;
    end else begin
      state      <= state_next;
      rd_pending <= cmd.rd_en;
    end
  end

endmodule

`default_nettype wire

>>> design/irt_dp.sv
`default_nettype none

module irt_dp (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire irt_pkg::irt_cmd_t          cmd,
  output irt_pkg::irt_sts_t               sts,
  input  wire logic [31:0]                start_time,
  input  wire logic [31:0]                end_time,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [1:0]                      status
);

  logic [irt_pkg::TIME_W-1:0]   req_start;
  logic [irt_pkg::TIME_W-1:0]   req_end;
  logic [irt_pkg::CNT_W-1:0]    count;
  logic [irt_pkg::CNT_W-1:0]    idx;
  logic                         hit;
  logic [2*irt_pkg::TIME_W-1:0] rd_data;
  irt_pkg::status_t             status_q;
  irt_pkg::status_t             verdict;

  // Packed {start, end} per slot; slots 0..count-1 hold stored intervals
  logic [2*irt_pkg::TIME_W-1:0] mem [irt_pkg::ENTRIES];

  logic [irt_pkg::TIME_W-1:0] rd_start;
  logic [irt_pkg::TIME_W-1:0] rd_end;
  logic                       overlap;
  logic                       store;

  assign rd_start = rd_data[2*irt_pkg::TIME_W-1:irt_pkg::TIME_W];
  assign rd_end   = rd_data[irt_pkg::TIME_W-1:0];
  assign overlap  = (rd_start < req_end) && (req_start < rd_end);

  assign sts.invalid  = (req_end <= req_start);
  assign sts.full     = (count == irt_pkg::CNT_W'(irt_pkg::ENTRIES));
  assign sts.hit      = hit;
  assign sts.idx_done = (idx == count);
  assign sts.out_free = !out_valid || out_ready;

  always_comb begin
    if (sts.invalid) begin
      verdict = irt_pkg::ST_INVALID;
    end else if (sts.full) begin
      verdict = irt_pkg::ST_FULL;
    end else if (hit) begin
      verdict = irt_pkg::ST_CONFLICT;
    end else begin
      verdict = irt_pkg::ST_BOOKED;
    end
  end

  assign store = cmd.commit && (verdict == irt_pkg::ST_BOOKED);

  always_ff @(posedge clk) begin
    if (store) begin
      mem[count[irt_pkg::ADDR_W-1:0]] <= {req_start, req_end};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[idx[irt_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_start <= start_time[irt_pkg::TIME_W-1:0];
      req_end   <= end_time[irt_pkg::TIME_W-1:0];
    end
    if (cmd.commit) begin
      status_q <= verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      idx       <= '0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (store) begin
        count <= count + irt_pkg::CNT_W'(1);
      end
      if (cmd.load_req) begin
        idx <= '0;
        hit <= 1'b0;
      end else begin
        if (cmd.rd_en) begin
          idx <= idx + irt_pkg::CNT_W'(1);
        end
        if (cmd.cmp_en && overlap) begin
          hit <= 1'b1;
        end
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status = status_q;

endmodule

`default_nettype wire
